// ===== design/spd_pkg.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// spd_pkg: shared types and constants of the sensor packet deframer
// Type byte codes, packet layouts, result kinds and the packet length table.
// ----------------------------------------------------------------------------
package spd_pkg;

    localparam logic [7:0] HDR_ACCEL      = 8'hA0;
    localparam logic [7:0] HDR_ACCEL_DROP = 8'hA8;
    localparam logic [7:0] HDR_EEG        = 8'hE0;
    localparam logic [7:0] HDR_EEG_DROP   = 8'hE8;
    localparam logic [7:0] HDR_DRL        = 8'h90;
    localparam logic [7:0] HDR_BAT        = 8'hB0;
    localparam logic [7:0] HDR_ERR        = 8'hD0;
    localparam logic [7:0] HDR_SYNC       = 8'hFF;

    // sync body after the type byte
    localparam logic [7:0] SYNC_BYTE1 = 8'hFF;
    localparam logic [7:0] SYNC_BYTE2 = 8'hAA;
    localparam logic [7:0] SYNC_BYTE3 = 8'h55;

    localparam int SAMPLE_W = 10;

    typedef enum logic [2:0] {
        LAY_ACC   = 3'd0,
        LAY_ACC_D = 3'd1,
        LAY_EEG   = 3'd2,
        LAY_EEG_D = 3'd3,
        LAY_DRL   = 3'd4,
        LAY_BAT   = 3'd5,
        LAY_ERR   = 3'd6,
        LAY_SYNC  = 3'd7
    } layout_t;

    typedef enum logic [2:0] {
        KIND_ACCEL   = 3'd0,
        KIND_EEG     = 3'd1,
        KIND_DRLREF  = 3'd2,
        KIND_BATTERY = 3'd3,
        KIND_ERROR   = 3'd4,
        KIND_SYNC    = 3'd5,
        KIND_BAD     = 3'd6
    } kind_t;

    typedef struct packed {
        logic [3:0]  byte_count;
        logic [31:0] error_word;
        logic [2:0]  num_channels;
        logic [15:0] chan3;
        logic [15:0] chan2;
        logic [15:0] chan1;
        logic [15:0] chan0;
        logic [15:0] dropped_count;
    } result_t;

    // total bytes of a packet, type byte included
    function automatic logic [3:0] total_len(input layout_t lay);
        case (lay)
            LAY_ACC:   total_len = 4'd5;
            LAY_ACC_D: total_len = 4'd7;
            LAY_EEG:   total_len = 4'd6;
            LAY_EEG_D: total_len = 4'd8;
            LAY_DRL:   total_len = 4'd4;
            LAY_BAT:   total_len = 4'd9;
            LAY_ERR:   total_len = 4'd5;
            default:   total_len = 4'd4;
        endcase
    endfunction

    function automatic logic [15:0] sample(input logic [63:0] s, input int sh);
        sample = {6'd0, s[sh +: SAMPLE_W]};
    endfunction

endpackage
`default_nettype wire

// ===== design/sensor_packet_deframer.sv =====
`default_nettype none
// A result appears on m_axis in the cycle after the last byte of its packet is accepted.
// Throughput: one byte per cycle; s_axis_tready stays high unless a result is held unread.
// Each packet or bad sequence gives one result, so results never outpace input bytes.
// Reset (aresetn low, synchronous): parser waits for a type byte, result register empty.
// ----------------------------------------------------------------------------
// sensor_packet_deframer
// Parses a byte stream of typed sensor packets into one decoded result each.
// ----------------------------------------------------------------------------
module sensor_packet_deframer
    import spd_pkg::*;
(
    input  wire logic         aclk,
    input  wire logic         aresetn,
    input  wire logic         s_axis_tvalid,
    output logic              s_axis_tready,
    input  wire logic [7:0]   s_axis_tdata,   // [7:0] byte_in
    output logic              m_axis_tvalid,
    input  wire logic         m_axis_tready,
    // [15:0] dropped_count, [31:16] chan0, [47:32] chan1, [63:48] chan2,
    // [79:64] chan3, [82:80] num_channels, [114:83] error_word,
    // [118:115] byte_count, [119] zero
    output logic [119:0]      m_axis_tdata,
    output logic [2:0]        m_axis_tuser    // [2:0] kind
);

    logic [3:0]  phase_reg, phase_next;
    layout_t     lay_reg, lay_next;
    logic [63:0] shift_reg, shift_next;
    logic        m_valid_reg;
    result_t     res_reg, res_next;
    kind_t       kind_reg, kind_next;
    logic        emit;
    logic        s_fire;
    logic [3:0]  phase_inc;
    logic [7:0]  sync_want;

    assign s_axis_tready = !m_valid_reg || m_axis_tready;
    assign s_fire        = s_axis_tvalid && s_axis_tready;
    assign phase_inc     = phase_reg + 4'd1;

    always_comb begin
        case (phase_reg)
            4'd1:    sync_want = SYNC_BYTE1;
            4'd2:    sync_want = SYNC_BYTE2;
            default: sync_want = SYNC_BYTE3;
        endcase
    end

    always_comb begin
        phase_next = phase_reg;
        lay_next   = lay_reg;
        shift_next = shift_reg;
        emit       = 1'b0;
        res_next   = '0;
        kind_next  = KIND_BAD;

        if (phase_reg == 4'd0) begin
            phase_next = 4'd1;
            shift_next = '0;
            case (s_axis_tdata)
                HDR_ACCEL:      lay_next = LAY_ACC;
                HDR_ACCEL_DROP: lay_next = LAY_ACC_D;
                HDR_EEG:        lay_next = LAY_EEG;
                HDR_EEG_DROP:   lay_next = LAY_EEG_D;
                HDR_DRL:        lay_next = LAY_DRL;
                HDR_BAT:        lay_next = LAY_BAT;
                HDR_ERR:        lay_next = LAY_ERR;
                HDR_SYNC:       lay_next = LAY_SYNC;
                default: begin
                    // unknown type: report bad, keep waiting for a type byte
                    phase_next          = 4'd0;
                    shift_next          = shift_reg;
                    emit                = 1'b1;
                    res_next.byte_count = 4'd1;
                end
            endcase
        end else if (lay_reg == LAY_SYNC && s_axis_tdata != sync_want) begin
            // broken sync: consume the byte and restart
            phase_next          = 4'd0;
            emit                = 1'b1;
            res_next.byte_count = phase_inc;
        end else begin
            if (lay_reg != LAY_SYNC) begin
                shift_next = {shift_reg[55:0], s_axis_tdata};
            end
            phase_next = phase_inc;
            if (phase_inc >= total_len(lay_reg)) begin
                phase_next          = 4'd0;
                emit                = 1'b1;
                res_next.byte_count = total_len(lay_reg);
                case (lay_reg)
                    LAY_ACC, LAY_ACC_D: begin
                        kind_next             = KIND_ACCEL;
                        res_next.dropped_count = (lay_reg == LAY_ACC_D)
                                               ? shift_next[47:32] : 16'd0;
                        res_next.chan0        = sample(shift_next, 22);
                        res_next.chan1        = sample(shift_next, 12);
                        res_next.chan2        = sample(shift_next, 2);
                        res_next.num_channels = 3'd3;
                    end
                    LAY_EEG, LAY_EEG_D: begin
                        kind_next             = KIND_EEG;
                        res_next.dropped_count = (lay_reg == LAY_EEG_D)
                                               ? shift_next[55:40] : 16'd0;
                        res_next.chan0        = sample(shift_next, 30);
                        res_next.chan1        = sample(shift_next, 20);
                        res_next.chan2        = sample(shift_next, 10);
                        res_next.chan3        = sample(shift_next, 0);
                        res_next.num_channels = 3'd4;
                    end
                    LAY_DRL: begin
                        kind_next             = KIND_DRLREF;
                        res_next.chan0        = sample(shift_next, 14);
                        res_next.chan1        = sample(shift_next, 4);
                        res_next.num_channels = 3'd2;
                    end
                    LAY_BAT: begin
                        kind_next             = KIND_BATTERY;
                        res_next.chan0        = shift_next[63:48];
                        res_next.chan1        = shift_next[47:32];
                        res_next.chan2        = shift_next[31:16];
                        res_next.chan3        = shift_next[15:0];
                        res_next.num_channels = 3'd4;
                    end
                    LAY_ERR: begin
                        kind_next           = KIND_ERROR;
                        res_next.error_word = shift_next[31:0];
                    end
                    default: begin
                        kind_next = KIND_SYNC;
                    end
                endcase
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg   <= 4'd0;
            lay_reg     <= LAY_ACC;
            shift_reg   <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            if (s_fire) begin
                phase_reg <= phase_next;
                lay_reg   <= lay_next;
                shift_reg <= shift_next;
            end
            if (s_fire && emit) begin
                m_valid_reg <= 1'b1;
            end else if (m_axis_tready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    // result payload: load on every emitting transaction
    always_ff @(posedge aclk) begin
        if (s_fire && emit) begin
            res_reg  <= res_next;
            kind_reg <= kind_next;
        end
    end

    assign m_axis_tvalid = m_valid_reg;
    assign m_axis_tdata  = {1'b0, res_reg};
    assign m_axis_tuser  = kind_reg;

    // parser never holds a count past the longest packet body
    a_phase_range: assert property (@(posedge aclk) disable iff (!aresetn)
        phase_reg <= 4'd8)
        else $error("phase count out of range");

    // sync sequence never advances past its third byte
    a_sync_phase: assert property (@(posedge aclk) disable iff (!aresetn)
        lay_reg == LAY_SYNC |-> phase_reg <= 4'd3)
        else $error("sync phase out of range");

    // an emitted result always returns the parser to the type byte
    a_emit_restart: assert property (@(posedge aclk) disable iff (!aresetn)
        s_fire && emit |=> phase_reg == 4'd0 && m_axis_tvalid)
        else $error("parser did not restart after a result");

    // a bad result carries only its byte count
    a_bad_fields: assert property (@(posedge aclk) disable iff (!aresetn)
        m_axis_tvalid && m_axis_tuser == KIND_BAD |->
            res_reg.num_channels == 3'd0 && res_reg.byte_count != 4'd0
            && res_reg.byte_count <= 4'd4)
        else $error("malformed bad result");

endmodule
`default_nettype wire

// ===== verif/tb.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb: self-checking bench for sensor_packet_deframer
// Streams typed packets, broken syncs and stray bytes into the deframer,
// predicts each decoded result, and checks it field by field as it leaves.
// ----------------------------------------------------------------------------
module tb
    import spd_pkg::*;
();

    localparam int HOLD_OFF_CYCLES = 200;
    localparam int PRINT_CAP       = 50;

    typedef struct {
        kind_t   kind;
        result_t fields;
    } decoded_packet_t;

    logic         aclk = 1'b0;
    logic         aresetn = 1'b0;
    logic         s_axis_tvalid = 1'b0;
    logic         s_axis_tready;
    logic [7:0]   s_axis_tdata = '0;      // [7:0] byte_in
    logic         m_axis_tvalid;
    logic         m_axis_tready = 1'b0;
    // [15:0] dropped_count, [31:16] chan0, [47:32] chan1, [63:48] chan2,
    // [79:64] chan3, [82:80] num_channels, [114:83] error_word,
    // [118:115] byte_count, [119] zero
    logic [119:0] m_axis_tdata;
    logic [2:0]   m_axis_tuser;           // [2:0] kind

    // parser state of the prediction
    logic [3:0]  parse_phase = '0;
    layout_t     parse_lay = LAY_ACC;
    logic [63:0] parse_shift = '0;

    decoded_packet_t pending_packets[$];

    int error_count = 0;
    int bytes_sent = 0;
    int results_checked = 0;
    int input_stall_cycles = 0;
    int kind_hits[7];
    int src_idle_pct = 0;
    int sink_stall_pct = 0;
    bit hold_off_req = 1'b0;

    sensor_packet_deframer dut (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser)
    );

    always #4 aclk = ~aclk;

    initial begin
        #5_000_000;
        $display("[sensor_packet_deframer] ERROR");
        $finish;
    end

    task automatic report_mismatch(input string msg);
        if (error_count < PRINT_CAP)
            $display("%0t mismatch: %s", $realtime, msg);
        error_count++;
    endtask

    task automatic check_field(input string name, input logic [31:0] got,
                               input logic [31:0] want);
        if (got !== want)
            report_mismatch($sformatf("result %0d %s: got %0h, want %0h",
                                      results_checked, name, got, want));
    endtask

    // total bytes of a packet, type byte included
    function automatic logic [3:0] packet_len(input layout_t lay);
        case (lay)
            LAY_ACC:   return 4'd5;
            LAY_ACC_D: return 4'd7;
            LAY_EEG:   return 4'd6;
            LAY_EEG_D: return 4'd8;
            LAY_DRL:   return 4'd4;
            LAY_BAT:   return 4'd9;
            LAY_ERR:   return 4'd5;
            default:   return 4'd4;
        endcase
    endfunction

    // advance the predicted parser by one accepted byte; queue any result
    function automatic void deframe_byte(input logic [7:0] b);
        result_t    f;
        kind_t      k;
        logic [7:0] want;
        logic [3:0] len;
        f = '0;
        if (parse_phase == 4'd0) begin
            parse_shift = '0;
            parse_phase = 4'd1;
            case (b)
                HDR_ACCEL:      parse_lay = LAY_ACC;
                HDR_ACCEL_DROP: parse_lay = LAY_ACC_D;
                HDR_EEG:        parse_lay = LAY_EEG;
                HDR_EEG_DROP:   parse_lay = LAY_EEG_D;
                HDR_DRL:        parse_lay = LAY_DRL;
                HDR_BAT:        parse_lay = LAY_BAT;
                HDR_ERR:        parse_lay = LAY_ERR;
                HDR_SYNC:       parse_lay = LAY_SYNC;
                default: begin
                    parse_phase = 4'd0;
                    f.byte_count = 4'd1;
                    pending_packets.push_back('{KIND_BAD, f});
                end
            endcase
            return;
        end
        if (parse_lay == LAY_SYNC) begin
            want = (parse_phase == 4'd1) ? SYNC_BYTE1 :
                   (parse_phase == 4'd2) ? SYNC_BYTE2 : SYNC_BYTE3;
            if (b != want) begin
                // the offending byte is consumed with the broken sequence
                f.byte_count = parse_phase + 4'd1;
                parse_phase = 4'd0;
                pending_packets.push_back('{KIND_BAD, f});
                return;
            end
        end else begin
            parse_shift = {parse_shift[55:0], b};
        end
        parse_phase = parse_phase + 4'd1;
        len = packet_len(parse_lay);
        if (parse_phase < len)
            return;
        parse_phase = 4'd0;
        f.byte_count = len;
        case (parse_lay)
            LAY_ACC, LAY_ACC_D: begin
                k = KIND_ACCEL;
                if (parse_lay == LAY_ACC_D)
                    f.dropped_count = parse_shift[47:32];
                f.chan0 = 16'(parse_shift[31:22]);
                f.chan1 = 16'(parse_shift[21:12]);
                f.chan2 = 16'(parse_shift[11:2]);
                f.num_channels = 3'd3;
            end
            LAY_EEG, LAY_EEG_D: begin
                k = KIND_EEG;
                if (parse_lay == LAY_EEG_D)
                    f.dropped_count = parse_shift[55:40];
                f.chan0 = 16'(parse_shift[39:30]);
                f.chan1 = 16'(parse_shift[29:20]);
                f.chan2 = 16'(parse_shift[19:10]);
                f.chan3 = 16'(parse_shift[9:0]);
                f.num_channels = 3'd4;
            end
            LAY_DRL: begin
                k = KIND_DRLREF;
                f.chan0 = 16'(parse_shift[23:14]);
                f.chan1 = 16'(parse_shift[13:4]);
                f.num_channels = 3'd2;
            end
            LAY_BAT: begin
                k = KIND_BATTERY;
                f.chan0 = parse_shift[63:48];
                f.chan1 = parse_shift[47:32];
                f.chan2 = parse_shift[31:16];
                f.chan3 = parse_shift[15:0];
                f.num_channels = 3'd4;
            end
            LAY_ERR: begin
                k = KIND_ERROR;
                f.error_word = parse_shift[31:0];
            end
            default: k = KIND_SYNC;
        endcase
        pending_packets.push_back('{k, f});
    endfunction

    task automatic send_byte(input logic [7:0] b);
        while ($urandom_range(99) < src_idle_pct) begin
            s_axis_tvalid <= 1'b0;
            @(posedge aclk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= b;
        do @(posedge aclk); while (!s_axis_tready);
        bytes_sent++;
        deframe_byte(b);
    endtask

    // fill: 0 random, 1 all zeros, 2 all ones
    task automatic send_packet(input layout_t lay, input int fill);
        logic [7:0] b;
        case (lay)
            LAY_ACC:   send_byte(HDR_ACCEL);
            LAY_ACC_D: send_byte(HDR_ACCEL_DROP);
            LAY_EEG:   send_byte(HDR_EEG);
            LAY_EEG_D: send_byte(HDR_EEG_DROP);
            LAY_DRL:   send_byte(HDR_DRL);
            LAY_BAT:   send_byte(HDR_BAT);
            LAY_ERR:   send_byte(HDR_ERR);
            default:   send_byte(HDR_SYNC);
        endcase
        if (lay == LAY_SYNC) begin
            send_byte(SYNC_BYTE1);
            send_byte(SYNC_BYTE2);
            send_byte(SYNC_BYTE3);
            return;
        end
        for (int i = 1; i < int'(packet_len(lay)); i++) begin
            if (fill == 1)
                b = 8'h00;
            else if (fill == 2)
                b = 8'hFF;
            else if ($urandom_range(7) == 0)
                b = $urandom_range(1) ? 8'hFF : 8'h00;
            else
                b = 8'($urandom_range(255));
            send_byte(b);
        end
    endtask

    // break a sync sequence on its body byte number at (1..3)
    task automatic send_broken_sync(input int at);
        logic [7:0] want;
        logic [7:0] b;
        send_byte(HDR_SYNC);
        if (at > 1) send_byte(SYNC_BYTE1);
        if (at > 2) send_byte(SYNC_BYTE2);
        want = (at == 1) ? SYNC_BYTE1 : (at == 2) ? SYNC_BYTE2 : SYNC_BYTE3;
        do b = 8'($urandom_range(255)); while (b == want);
        send_byte(b);
    endtask

    // pad with zeros until the parser waits for a type byte
    task automatic realign();
        while (parse_phase != 4'd0)
            send_byte(8'h00);
    endtask

    task automatic test_directed();
        send_packet(LAY_ACC, 2);
        send_packet(LAY_ACC_D, 1);
        send_packet(LAY_EEG, 2);
        send_packet(LAY_EEG_D, 2);
        send_packet(LAY_DRL, 2);
        send_packet(LAY_BAT, 2);
        send_packet(LAY_BAT, 1);
        send_packet(LAY_ERR, 0);
        send_packet(LAY_SYNC, 0);
        send_byte(8'h00);
        send_byte(8'hA1);
        send_broken_sync(1);
        send_broken_sync(2);
        send_broken_sync(3);
    endtask

    task automatic test_random(input int src_idle, input int sink_stall, input int n);
        int pick;
        int target;
        src_idle_pct   = src_idle;
        sink_stall_pct = sink_stall;
        target = bytes_sent + n;
        while (bytes_sent < target) begin
            pick = $urandom_range(99);
            if (pick < 80)
                send_packet(layout_t'($urandom_range(7)), 0);
            else if (pick < 90)
                send_broken_sync($urandom_range(1, 3));
            else
                repeat ($urandom_range(1, 3)) send_byte(8'($urandom_range(255)));
        end
    endtask

    // hold the result side off while packets keep coming, so the input stalls
    task automatic test_backpressure();
        src_idle_pct   = 0;
        sink_stall_pct = 0;
        realign();
        hold_off_req = 1'b1;
        repeat (8) send_packet(LAY_DRL, 0);
        wait (!hold_off_req);
    endtask

    // result side: random stalls, plus one long hold-off on request
    initial begin
        forever begin
            @(posedge aclk);
            if (hold_off_req) begin
                m_axis_tready <= 1'b0;
                repeat (HOLD_OFF_CYCLES) @(posedge aclk);
                hold_off_req = 1'b0;
            end
            m_axis_tready <= ($urandom_range(99) >= sink_stall_pct);
        end
    end

    always @(posedge aclk) begin
        decoded_packet_t want;
        result_t         got;
        if (aresetn) begin
            if (s_axis_tvalid && !s_axis_tready)
                input_stall_cycles++;
            if (m_axis_tvalid && m_axis_tready) begin
                got = m_axis_tdata[118:0];
                if (pending_packets.size() == 0) begin
                    report_mismatch($sformatf("result with nothing pending, kind %0d",
                                              m_axis_tuser));
                end else begin
                    want = pending_packets.pop_front();
                    check_field("kind", 32'(m_axis_tuser), 32'(want.kind));
                    check_field("dropped_count", 32'(got.dropped_count),
                                32'(want.fields.dropped_count));
                    check_field("chan0", 32'(got.chan0), 32'(want.fields.chan0));
                    check_field("chan1", 32'(got.chan1), 32'(want.fields.chan1));
                    check_field("chan2", 32'(got.chan2), 32'(want.fields.chan2));
                    check_field("chan3", 32'(got.chan3), 32'(want.fields.chan3));
                    check_field("num_channels", 32'(got.num_channels),
                                32'(want.fields.num_channels));
                    check_field("error_word", got.error_word, want.fields.error_word);
                    check_field("byte_count", 32'(got.byte_count),
                                32'(want.fields.byte_count));
                    check_field("pad bit", 32'(m_axis_tdata[119]), 32'd0);
                    if (int'(want.kind) < 7)
                        kind_hits[want.kind]++;
                end
                results_checked++;
            end
        end
    end

    initial begin
        int guard;
        repeat (10) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        test_directed();
        test_random(0, 0, 380);
        test_random(66, 0, 380);
        test_random(0, 66, 380);
        test_random(26, 26, 380);
        test_backpressure();

        s_axis_tvalid <= 1'b0;
        sink_stall_pct = 0;
        guard = 0;
        while (pending_packets.size() != 0 && guard < 10000) begin
            @(posedge aclk);
            guard++;
        end
        repeat (10) @(posedge aclk);
        if (pending_packets.size() != 0)
            report_mismatch($sformatf("%0d results never arrived",
                                      pending_packets.size()));

        $display("%0d bytes streamed, %0d results checked, input stalled %0d cycles",
                 bytes_sent, results_checked, input_stall_cycles);
        $display("accel %0d, eeg %0d, drl/ref %0d, battery %0d, error %0d, sync %0d, bad %0d",
                 kind_hits[KIND_ACCEL], kind_hits[KIND_EEG], kind_hits[KIND_DRLREF],
                 kind_hits[KIND_BATTERY], kind_hits[KIND_ERROR], kind_hits[KIND_SYNC],
                 kind_hits[KIND_BAD]);
        if (error_count == 0)
            $display("[sensor_packet_deframer] OK");
        else
            $display("[sensor_packet_deframer] ERROR");
        $finish;
    end

endmodule

// ===== sim.f =====
design/spd_pkg.sv
design/sensor_packet_deframer.sv
verif/tb.sv
